// ===== rtl/pcsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsp_pkg
// Shared types and constants of the pixel command stream parser.
// ----------------------------------------------------------------------------
package pcsp_pkg;

  // Parser phases
  typedef enum logic [1:0] {
    PH_SCAN = 2'd0,
    PH_COL  = 2'd1,
    PH_ROW  = 2'd2,
    PH_HEX  = 2'd3
  } pcsp_phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_READ = 2'd1,
    KIND_SIZE = 2'd2,
    KIND_HELP = 2'd3
  } pcsp_kind_t;

  // Configuration register indexes
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [15:0] WIDTH_RESET  = 16'd1920;
  localparam logic [15:0] HEIGHT_RESET = 16'd1080;

  // ASCII codes used by the protocol
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_X       = 8'h58;
  localparam logic [7:0] CH_S       = 8'h53;
  localparam logic [7:0] CH_I       = 8'h49;
  localparam logic [7:0] CH_Z       = 8'h5A;
  localparam logic [7:0] CH_E       = 8'h45;
  localparam logic [7:0] CH_H       = 8'h48;
  localparam logic [7:0] CH_L       = 8'h4C;

  // Colour is six hex digits
  localparam logic [2:0] COLOUR_DIGITS = 3'd6;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
    logic       is_digit;
    logic       is_hex;
    logic [3:0] nibble;
    logic       is_space;
    logic       is_newline;
  } pcsp_item_t;

endpackage

// ===== rtl/pixel_command_stream_parser.sv =====
`timescale 1ns / 1ps
// A word accepted into the queue is parsed at the queue head and its command is registered in the result register.
// The back takes one word per cycle while its result register is empty or being taken.
// A four-entry queue lets the input keep taking words while a result waits.
// Reset (rst_n low, synchronous) empties the queue, drops any result, returns
// the parser to keyword scan and loads screen size 1920 x 1080.
// ----------------------------------------------------------------------------
// pixel_command_stream_parser
// Text pixel protocol parser: byte stream in, set/read/size/help commands out.
// ----------------------------------------------------------------------------
module pixel_command_stream_parser
  import pcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // chunk_end
  // command stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] pixel_x, [31:16] pixel_y, [55:32] pixel_color
  output logic [1:0]  out_tuser,  // [1:0] command_kind
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] width_r;
  logic [15:0] height_r;
  pcsp_item_t  front_item;
  pcsp_item_t  head_item;
  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  pcsp_kind_t  res_kind;
  logic [15:0] res_x;
  logic [15:0] res_y;
  logic [23:0] res_color;

  // Screen size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        CFG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  pcsp_front u_front (
    .data_byte (in_tdata),
    .chunk_end (in_tlast),
    .item      (front_item)
  );

  pcsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  pcsp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (!q_empty),
    .item          (head_item),
    .item_pop      (q_pop),
    .screen_width  (width_r),
    .screen_height (height_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_kind      (res_kind),
    .out_x         (res_x),
    .out_y         (res_y),
    .out_color     (res_color)
  );

  assign out_tdata = {res_color, res_y, res_x};
  assign out_tuser = res_kind;

endmodule

// ===== rtl/pcsp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsp_front
// Classifies each received byte (digit, hex nibble, space, newline).
// ----------------------------------------------------------------------------
module pcsp_front
  import pcsp_pkg::*;
(
  input  logic [7:0]  data_byte,
  input  logic        chunk_end,
  output pcsp_item_t  item
);

  // Decode the byte class and its nibble value
  always_comb begin
    item            = '0;
    item.data_byte  = data_byte;
    item.chunk_end  = chunk_end;
    item.is_space   = (data_byte == CH_SPACE);
    item.is_newline = (data_byte == CH_NEWLINE);
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      item.is_digit = 1'b1;
      item.is_hex   = 1'b1;
      item.nibble   = data_byte[3:0];
    end else if (data_byte >= 8'h61 && data_byte <= 8'h66) begin
      item.is_hex = 1'b1;
      item.nibble = data_byte[3:0] + 4'd9;
    end else if (data_byte >= 8'h41 && data_byte <= 8'h46) begin
      item.is_hex = 1'b1;
      item.nibble = data_byte[3:0] + 4'd9;
    end
  end

endmodule

// ===== rtl/pcsp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsp_queue
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module pcsp_queue
  import pcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  pcsp_item_t  push_item,
  input  logic        pop,
  output pcsp_item_t  head_item,
  output logic        full,
  output logic        empty
);

  pcsp_item_t            slot_r [QDEPTH];
  logic [QAW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]          count_r, count_nxt;

  assign full      = (count_r == (QAW+1)'(QDEPTH));
  assign empty     = (count_r == '0);
  assign head_item = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QAW'(push);
    rd_ptr_nxt = rd_ptr_r + QAW'(pop);
    count_nxt  = count_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/pcsp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsp_back
// Keyword scan and command parser; one word a cycle, unless a held result is not yet taken, into a result register.
// ----------------------------------------------------------------------------
module pcsp_back
  import pcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  pcsp_item_t  item,
  output logic        item_pop,
  input  logic [15:0] screen_width,
  input  logic [15:0] screen_height,
  output logic        out_valid,
  input  logic        out_ready,
  output pcsp_kind_t  out_kind,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic [23:0] out_color
);

  pcsp_phase_t phase_r, phase_nxt;
  logic [23:0] recent_r, recent_nxt;
  logic [1:0]  rcount_r, rcount_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [23:0] colour_r, colour_nxt;
  logic [2:0]  digits_r, digits_nxt;
  logic        stopped_r, stopped_nxt;

  logic        valid_r, valid_nxt;
  pcsp_kind_t  kind_r, kind_nxt;
  logic [15:0] x_r, x_nxt;
  logic [15:0] y_r, y_nxt;
  logic [23:0] color_r, color_nxt;

  logic        emit;
  logic        rescan;
  logic        do_scan;
  logic [2:0]  digits_inc;
  logic [7:0]  b;

  assign item_pop  = item_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_color = color_r;
  assign b         = item.data_byte;
  assign digits_inc = digits_r + 3'd1;

  // Parse one word
  always_comb begin
    phase_nxt   = phase_r;
    recent_nxt  = recent_r;
    rcount_nxt  = rcount_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    colour_nxt  = colour_r;
    digits_nxt  = digits_r;
    stopped_nxt = stopped_r;
    emit        = 1'b0;
    rescan      = 1'b0;
    kind_nxt    = kind_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    color_nxt   = color_r;

    unique case (phase_r)
      PH_COL: begin
        if (item.is_digit) begin
          col_nxt = (col_r << 3) + (col_r << 1) + {12'd0, item.nibble};
        end else if (item.is_space) begin
          phase_nxt = PH_ROW;
          row_nxt   = '0;
        end else begin
          phase_nxt = PH_SCAN;
        end
      end
      PH_ROW: begin
        if (item.is_digit) begin
          row_nxt = (row_r << 3) + (row_r << 1) + {12'd0, item.nibble};
        end else if (col_r >= screen_width || row_r >= screen_height) begin
          phase_nxt = PH_SCAN;
          rescan    = 1'b1;
        end else if (item.is_space) begin
          phase_nxt   = PH_HEX;
          colour_nxt  = '0;
          digits_nxt  = '0;
          stopped_nxt = 1'b0;
        end else if (item.is_newline) begin
          emit      = 1'b1;
          kind_nxt  = KIND_READ;
          x_nxt     = col_r;
          y_nxt     = row_r;
          color_nxt = '0;
          phase_nxt = PH_SCAN;
        end else begin
          phase_nxt = PH_SCAN;
          rescan    = 1'b1;
        end
      end
      PH_HEX: begin
        if (!stopped_r) begin
          colour_nxt = {colour_r[19:0], item.is_hex ? item.nibble : 4'd0};
          if (!item.is_hex) begin
            stopped_nxt = 1'b1;
          end
        end
        if (digits_inc >= COLOUR_DIGITS) begin
          // swap red and blue
          emit        = 1'b1;
          kind_nxt    = KIND_SET;
          x_nxt       = col_r;
          y_nxt       = row_r;
          color_nxt   = {colour_nxt[7:0], colour_nxt[15:8], colour_nxt[23:16]};
          phase_nxt   = PH_SCAN;
          digits_nxt  = '0;
          stopped_nxt = 1'b0;
        end else begin
          digits_nxt = digits_inc;
        end
      end
      default: begin
      end
    endcase

    // Keyword window, also for a byte handed back by the row phase
    do_scan = (phase_r == PH_SCAN) || rescan;
    if (do_scan) begin
      if (rcount_r >= 2'd2 && recent_r[15:0] == {CH_P, CH_X} && b == CH_SPACE) begin
        recent_nxt = '0;
        rcount_nxt = '0;
        phase_nxt  = PH_COL;
        col_nxt    = '0;
        row_nxt    = '0;
      end else if (rcount_r == 2'd3 && recent_r == {CH_S, CH_I, CH_Z} && b == CH_E) begin
        recent_nxt = '0;
        rcount_nxt = '0;
        emit       = 1'b1;
        kind_nxt   = KIND_SIZE;
        x_nxt      = screen_width;
        y_nxt      = screen_height;
        color_nxt  = '0;
      end else if (rcount_r == 2'd3 && recent_r == {CH_H, CH_E, CH_L} && b == CH_P) begin
        recent_nxt = '0;
        rcount_nxt = '0;
        emit       = 1'b1;
        kind_nxt   = KIND_HELP;
        x_nxt      = '0;
        y_nxt      = '0;
        color_nxt  = '0;
      end else begin
        recent_nxt = {recent_r[15:0], b};
        if (rcount_r != 2'd3) begin
          rcount_nxt = rcount_r + 2'd1;
        end
      end
    end

    // Drop partial work at the end of a chunk
    if (item.chunk_end) begin
      phase_nxt   = PH_SCAN;
      recent_nxt  = '0;
      rcount_nxt  = '0;
      digits_nxt  = '0;
      stopped_nxt = 1'b0;
    end

    // Result register: load on emit, clear when taken
    if (item_pop) begin
      valid_nxt = emit;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SCAN;
      recent_r  <= '0;
      rcount_r  <= '0;
      col_r     <= '0;
      row_r     <= '0;
      colour_r  <= '0;
      digits_r  <= '0;
      stopped_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (item_pop) begin
        phase_r   <= phase_nxt;
        recent_r  <= recent_nxt;
        rcount_r  <= rcount_nxt;
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        colour_r  <= colour_nxt;
        digits_r  <= digits_nxt;
        stopped_r <= stopped_nxt;
      end
    end
  end

  // Hold result payload until the next emitted command
  always_ff @(posedge clk) begin
    if (item_pop && emit) begin
      kind_r  <= kind_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      color_r <= color_nxt;
    end
  end

endmodule

// ===== test/pixel_command_stream_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_command_stream_parser_tb
// Self-checking bench for the text pixel command parser. Byte streams built
// from well-formed, broken and noisy commands are pushed through the input
// stream under random back-pressure. A scoreboard predicts every command and
// compares it field by field with what the block emits. The run covers
// several screen sizes, including the extremes.
// ----------------------------------------------------------------------------
import pcsp_pkg::*;

typedef struct packed {
  pcsp_kind_t  kind;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [23:0] pixel_color;
} pixel_command_t;

typedef struct packed {
  logic [7:0] data_byte;
  logic       chunk_end;
} stream_word_t;

class command_scoreboard;
  // parser shadow state
  logic [15:0]  screen_w;
  logic [15:0]  screen_h;
  logic [23:0]  window;
  int           window_fill;
  pcsp_phase_t  phase;
  logic [15:0]  column;
  logic [15:0]  row;
  logic [23:0]  colour;
  logic [2:0]   hex_seen;
  bit           hex_frozen;

  pixel_command_t pending_commands[$];
  int             errors;

  function new();
    screen_w    = WIDTH_RESET;
    screen_h    = HEIGHT_RESET;
    window      = '0;
    window_fill = 0;
    phase       = PH_SCAN;
    column      = '0;
    row         = '0;
    colour      = '0;
    hex_seen    = '0;
    hex_frozen  = 1'b0;
    errors      = 0;
  endfunction

  function void set_register(logic idx, logic [15:0] value);
    if (idx == CFG_SCREEN_WIDTH) begin
      screen_w = value;
    end else begin
      screen_h = value;
    end
  endfunction

  function bit is_decimal(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function int hex_value(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  // Slide the keyword window; report SIZE / HELP, arm the coordinate parse on "PX "
  function bit match_keyword(logic [7:0] b, output pixel_command_t cmd);
    cmd = '0;
    if (window_fill >= 2 && window[15:0] == {CH_P, CH_X} && b == CH_SPACE) begin
      window      = '0;
      window_fill = 0;
      phase       = PH_COL;
      column      = '0;
      row         = '0;
      return 1'b0;
    end
    if (window_fill >= 3) begin
      if (window == {CH_S, CH_I, CH_Z} && b == CH_E) begin
        window      = '0;
        window_fill = 0;
        cmd         = '{KIND_SIZE, screen_w, screen_h, 24'd0};
        return 1'b1;
      end
      if (window == {CH_H, CH_E, CH_L} && b == CH_P) begin
        window      = '0;
        window_fill = 0;
        cmd         = '{KIND_HELP, 16'd0, 16'd0, 24'd0};
        return 1'b1;
      end
    end
    window = {window[15:0], b};
    if (window_fill < 3) window_fill++;
    return 1'b0;
  endfunction

  // Advance the shadow parser by one accepted word and queue any command it makes
  function void note_word(logic [7:0] b, logic last);
    pixel_command_t cmd;
    bit             made;
    bit             rescan;
    int             nib;
    made   = 1'b0;
    rescan = 1'b0;
    cmd    = '0;
    case (phase)
      PH_COL: begin
        if (is_decimal(b)) begin
          column = column * 16'd10 + {8'd0, b} - 16'd48;
        end else if (b == CH_SPACE) begin
          phase = PH_ROW;
          row   = '0;
        end else begin
          phase = PH_SCAN;
        end
      end
      PH_ROW: begin
        if (is_decimal(b)) begin
          row = row * 16'd10 + {8'd0, b} - 16'd48;
        end else if (column >= screen_w || row >= screen_h) begin
          phase  = PH_SCAN;
          rescan = 1'b1;
        end else if (b == CH_SPACE) begin
          phase      = PH_HEX;
          colour     = '0;
          hex_seen   = '0;
          hex_frozen = 1'b0;
        end else if (b == CH_NEWLINE) begin
          cmd   = '{KIND_READ, column, row, 24'd0};
          made  = 1'b1;
          phase = PH_SCAN;
        end else begin
          phase  = PH_SCAN;
          rescan = 1'b1;
        end
      end
      PH_HEX: begin
        if (!hex_frozen) begin
          nib    = hex_value(b);
          colour = {colour[19:0], 4'd0};
          if (nib >= 0) colour[3:0] = nib[3:0];
          else hex_frozen = 1'b1;
        end
        hex_seen = hex_seen + 3'd1;
        if (hex_seen >= COLOUR_DIGITS) begin
          // swap red and blue: text order RRGGBB becomes 0xBBGGRR
          cmd        = '{KIND_SET, column, row, {colour[7:0], colour[15:8], colour[23:16]}};
          made       = 1'b1;
          phase      = PH_SCAN;
          hex_seen   = '0;
          hex_frozen = 1'b0;
        end
      end
      default: made = match_keyword(b, cmd);
    endcase

    if (rescan) made = match_keyword(b, cmd);

    // chunk end drops partial work after the word itself is handled
    if (last) begin
      phase       = PH_SCAN;
      window      = '0;
      window_fill = 0;
      hex_seen    = '0;
      hex_frozen  = 1'b0;
    end

    if (made) pending_commands.push_back(cmd);
  endfunction

  function void flag(string what, longint want, longint got);
    errors++;
    if (errors <= 10) $display("  %s: expected %0h, got %0h", what, want, got);
  endfunction

  // Compare one emitted command with the oldest prediction
  function void check_result(logic [1:0] kind, logic [55:0] data);
    pixel_command_t want;
    if (pending_commands.size() == 0) begin
      flag("command with none predicted", 0, {kind, data});
      return;
    end
    want = pending_commands.pop_front();
    if (pcsp_kind_t'(kind) != want.kind) flag("command_kind", want.kind, kind);
    if (data[15:0] != want.pixel_x) flag("pixel_x", want.pixel_x, data[15:0]);
    if (data[31:16] != want.pixel_y) flag("pixel_y", want.pixel_y, data[31:16]);
    if (data[55:32] != want.pixel_color) flag("pixel_color", want.pixel_color, data[55:32]);
  endfunction
endclass

module pixel_command_stream_parser_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [15:0] cfg_wdata  = 16'd0;

  command_scoreboard sb = new();

  stream_word_t word_q[$];
  logic [7:0]   cmd_bytes[$];
  int           pending_words = 0;
  int           words_pushed  = 0;
  int           width_now     = 1920;
  int           height_now    = 1080;
  int           cycle_count   = 0;
  bit           calm          = 1'b0;
  bit           hold_request  = 1'b0;

  pixel_command_stream_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pixel_command_stream_parser: mismatch");
      $finish;
    end
  end

  // Byte sender: note accepted words, hold an offer until taken, idle in bursts
  initial begin : send_words
    stream_word_t w;
    int           gap_left;
    int           stretch_left;
    bit           quiet;
    gap_left     = 0;
    stretch_left = 0;
    quiet        = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && in_tvalid && in_tready) begin
        sb.note_word(in_tdata, in_tlast);
        pending_words--;
      end
      if (stretch_left == 0) begin
        quiet        = ($urandom_range(0, 2) == 0);
        stretch_left = $urandom_range(20, 80);
      end else begin
        stretch_left--;
      end
      if (in_tvalid && !in_tready) begin
        // hold the current offer
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        gap_left  = $urandom_range(1, 11) - 1;
        in_tvalid <= 1'b0;
      end else if (word_q.size() > 0) begin
        w         = word_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= w.data_byte;
        in_tlast  <= w.chunk_end;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Command receiver: check accepted commands, stall in bursts or for a long hold-off
  initial begin : take_commands
    int stall_left;
    int hold_left;
    int stretch_left;
    bit quiet;
    stall_left   = 0;
    hold_left    = 0;
    stretch_left = 0;
    quiet        = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if (stretch_left == 0) begin
        quiet        = ($urandom_range(0, 2) == 0);
        stretch_left = $urandom_range(20, 80);
      end else begin
        stretch_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_tready   <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) cmd_bytes.push_back(s[i]);
  endtask

  // Move the staged bytes to the sender; chunk end either random or on the last byte
  task automatic send_command(bit random_ends, bit end_on_last);
    stream_word_t w;
    for (int i = 0; i < cmd_bytes.size(); i++) begin
      w.data_byte = cmd_bytes[i];
      w.chunk_end = (random_ends && $urandom_range(0, 39) == 0) ||
                    (end_on_last && i == cmd_bytes.size() - 1);
      word_q.push_back(w);
      pending_words++;
      words_pushed++;
    end
    cmd_bytes.delete();
  endtask

  task automatic directed(string s);
    add_text(s);
    send_command(1'b0, 1'b0);
  endtask

  function automatic int pick_coord(int limit);
    if (limit == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 65535);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, (limit > 100) ? 99 : limit - 1);
    return $urandom_range(0, limit - 1);
  endfunction

  // Decimal text, sometimes empty, zero-padded or past 16 bits
  function automatic string decimal_text(int v);
    case ($urandom_range(0, 19))
      0:       return "";
      1:       return $sformatf("%0d", v + 65536 * $urandom_range(1, 9));
      2:       return {"00", $sformatf("%0d", v)};
      default: return $sformatf("%0d", v);
    endcase
  endfunction

  task automatic add_hex();
    string lower;
    string upper;
    int    n;
    lower = "0123456789abcdef";
    upper = "0123456789ABCDEF";
    for (int i = 0; i < 6; i++) begin
      n = $urandom_range(0, 15);
      cmd_bytes.push_back($urandom_range(0, 1) ? lower[n] : upper[n]);
    end
    if ($urandom_range(0, 9) == 0) cmd_bytes[$ - $urandom_range(0, 5)] = 8'($urandom_range(0, 255));
  endtask

  // One random command: mostly well formed, some broken, some noise
  task automatic random_command();
    int r;
    bit broken;
    bit is_set;
    int n;
    r      = $urandom_range(0, 99);
    broken = (r >= 58 && r < 70);
    is_set = (r < 40) || (broken && r % 2 == 0);
    if (r < 70) begin
      add_text({"PX ", decimal_text(pick_coord(width_now)), " ",
                decimal_text(pick_coord(height_now))});
      if (is_set) begin
        add_text(" ");
        add_hex();
        if ($urandom_range(0, 1)) add_text("\n");
      end else begin
        add_text("\n");
      end
      if (broken) begin
        if ($urandom_range(0, 1)) begin
          cmd_bytes[$urandom_range(0, cmd_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end else begin
          n = $urandom_range(1, cmd_bytes.size() - 1);
          while (cmd_bytes.size() > n) void'(cmd_bytes.pop_back());
        end
      end
    end else if (r < 78) begin
      add_text("SIZE");
    end else if (r < 86) begin
      add_text("HELP");
    end else begin
      case ($urandom_range(0, 2))
        0:       add_text("SIZ");
        1:       add_text("PX");
        default: add_text("HEL");
      endcase
      repeat ($urandom_range(1, 6)) cmd_bytes.push_back(8'($urandom_range(0, 255)));
    end
    send_command(1'b1, 1'b0);
  endtask

  task automatic random_commands(int words);
    int goal;
    goal = words_pushed + words;
    while (words_pushed < goal) random_command();
  endtask

  task automatic wait_drained();
    while (pending_words != 0 || sb.pending_commands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
    if (idx == CFG_SCREEN_WIDTH) width_now = int'(value);
    else height_now = int'(value);
  endtask

  task automatic set_screen(logic [15:0] w, logic [15:0] h);
    write_register(CFG_SCREEN_WIDTH, w);
    write_register(CFG_SCREEN_HEIGHT, h);
  endtask

  initial begin : main_flow
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset screen size: extremes, every kind and the awkward bytes
    directed("PX 0 0 000000");
    directed("PX 1919 1079 FFFFFF\n");
    directed("PX 12 34 a1B2c3");
    directed("PX 12 34\n");
    directed("PX 1920 5\n");
    directed("PX 5 1080 ");
    directed("PX 7x");
    directed("PX 7 8SIZE");
    directed("PX 3 4 12g456");
    directed("HELP");
    directed("PX 65537 2\n");
    add_text("PX 1 2 ab");
    send_command(1'b0, 1'b1);
    directed("cdef00");
    add_text("PX 9 9\n");
    send_command(1'b0, 1'b1);
    cmd_bytes.push_back(8'hFF);
    cmd_bytes.push_back(8'h80);
    send_command(1'b0, 1'b0);
    directed("PXX PX 4 4\n");
    random_commands(170);
    wait_drained();

    // one-pixel screen
    set_screen(16'd1, 16'd1);
    directed("PX 0 0\nPX 1 0\nPX 0 0 123abc");
    random_commands(170);
    wait_drained();

    // largest screen; receiver holds off so the input backs up
    set_screen(16'hFFFF, 16'hFFFF);
    hold_request = 1'b1;
    directed("PX 65534 65534 abcdef");
    directed("PX 65535 0\nSIZE");
    random_commands(170);
    wait_drained();

    // zero size rejects every coordinate
    set_screen(16'd0, 16'd0);
    directed("PX 0 0\nPX 0 0 123456SIZE");
    random_commands(50);
    wait_drained();

    set_screen(16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)));
    random_commands(170);
    wait_drained();

    // closing stretch at full rate
    calm = 1'b1;
    set_screen(16'd1920, 16'd1080);
    random_commands(120);
    wait_drained();

    if (sb.errors == 0 && sb.pending_commands.size() == 0) begin
      $display("pixel_command_stream_parser: match");
    end else begin
      $display("pixel_command_stream_parser: mismatch");
    end
    $finish;
  end

endmodule
